// ===== src/sosc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sosc_pkg
// Shared types and constants for the set-of-stacks block.
// ----------------------------------------------------------------------------
package sosc_pkg;

   // Default geometry
   localparam int NUM_STACKS_DEF   = 16;
   localparam int MAX_CAPACITY_DEF = 16;

   // Capacity register
   localparam logic [4:0] CAPACITY_RESET = 5'd10;
   localparam logic       CSR_CAPACITY   = 1'b0;   // register index 0

   // Value returned by top on an empty structure
   localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;

   // Operation codes
   typedef enum logic [1:0] {
      KIND_PUSH   = 2'd0,
      KIND_POP    = 2'd1,
      KIND_TOP    = 2'd2,
      KIND_POP_AT = 2'd3
   } kind_type;

   // Status codes
   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_BADIDX = 2'd3
   } status_type;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CNT  = 5'b00010,
      S_BACK = 5'b00100,
      S_DATA = 5'b01000,
      S_HOLD = 5'b10000
   } state_type;

endpackage

// ===== src/set_of_stacks_with_capacity_top.sv =====
`timescale 1ns / 1ps
// Sequence: on accept the count memory is read; in S_CNT push, pop and pop at index
//   finish and the result is registered; top also passes S_DATA for the plate memory read, a step back passes S_BACK.
// Requests: a new request is taken only in S_IDLE, after the count memory
//   read-modify-write and the plate memory read of the last one, and after S_HOLD.
// Reset (synchronous): counts read as zero via per-entry valid bits, pointer
//   to sub-stack 0, capacity 10; plate memory is not cleared.
// ----------------------------------------------------------------------------
// set_of_stacks_with_capacity_top
// Row of sub-stacks with a shared capacity limit behaving as one stack, with pop at index.
// ----------------------------------------------------------------------------
module set_of_stacks_with_capacity_top
   import sosc_pkg::*;
#(
   parameter int NUM_STACKS   = NUM_STACKS_DEF,
   parameter int MAX_CAPACITY = MAX_CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_data,
   input  logic [3:0]         req_index,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_all_empty,
   // configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int CUR_W   = $clog2(NUM_STACKS);
   localparam int CNT_W   = $clog2(MAX_CAPACITY + 1);
   localparam int PADDR_W = $clog2(NUM_STACKS * MAX_CAPACITY);
   localparam int P_DEPTH = NUM_STACKS * MAX_CAPACITY;

   // Slot of an entry in the plate memory
   function automatic logic [PADDR_W-1:0] slot_of(input logic [CUR_W-1:0] stk,
                                                  input logic [CNT_W-1:0] pos);
      slot_of = PADDR_W'(32'(stk) * MAX_CAPACITY + 32'(pos));
   endfunction

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   state_type                 state_ff, state_in;
   logic [CUR_W-1:0]          cur_ff, cur_in;
   logic [CNT_W-1:0]          fill0_ff, fill0_in;
   logic [4:0]                capacity_ff;
   kind_type                  kind_ff;
   logic signed [31:0]        data_ff;
   logic [CUR_W-1:0]          idx_ff;
   logic                      idx_bad_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]        rsp_value_ff;
   logic [1:0]                rsp_status_ff;
   logic                      rsp_all_empty_ff;

   logic signed [31:0]        hold_value_ff;
   logic [1:0]                hold_status_ff;
   logic                      hold_all_empty_ff;

   // Memories
   logic [CNT_W-1:0]          cnt_mem [NUM_STACKS];
   logic [NUM_STACKS-1:0]     cnt_vld_ff;
   logic [CNT_W-1:0]          cnt_rd_ff;
   logic                      cnt_vld_rd_ff;
   logic signed [31:0]        plate_mem [P_DEPTH];
   logic signed [31:0]        plate_rd_ff;

   // Memory ports
   logic [CUR_W-1:0]          cnt_raddr;
   logic                      cnt_we;
   logic [CUR_W-1:0]          cnt_waddr;
   logic [CNT_W-1:0]          cnt_wdata;
   logic                      plate_we;
   logic [PADDR_W-1:0]        plate_waddr;
   logic [PADDR_W-1:0]        plate_raddr;

   // Finish of a transaction
   logic                      fin;
   logic signed [31:0]        fin_value;
   status_type                fin_status;
   logic                      fin_all_empty;

   logic                      accept;
   logic                      rsp_free;
   logic [CNT_W-1:0]          cnt_now;
   logic [CNT_W-1:0]          cap_eff;
   logic                      csr_write;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_now   = cnt_vld_rd_ff ? cnt_rd_ff : '0;

   // Capacity clamped to 1..MAX_CAPACITY
   always_comb begin
      if (capacity_ff == 5'd0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(capacity_ff) > MAX_CAPACITY) begin
         cap_eff = CNT_W'(MAX_CAPACITY);
      end else begin
         cap_eff = CNT_W'(capacity_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Configuration port
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_CAPACITY) ? {27'd0, capacity_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write && csr_paddr[2] == CSR_CAPACITY) begin
         capacity_ff <= csr_pwdata[4:0];
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer: read count, decide, write back
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      cnt_we        = 1'b0;
      cnt_waddr     = cur_ff;
      cnt_wdata     = '0;
      plate_we      = 1'b0;
      plate_waddr   = slot_of(cur_ff, cnt_now);
      plate_raddr   = slot_of(cur_ff, cnt_now - CNT_W'(1));
      fin           = 1'b0;
      fin_value     = 32'sd0;
      fin_status    = STATUS_OK;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CNT;
            end
         end
         S_CNT: begin
            case (kind_ff)
               KIND_PUSH: begin
                  fin = 1'b1;
                  if (cnt_now >= cap_eff) begin
                     if (cur_ff == CUR_W'(NUM_STACKS - 1)) begin
                        fin_status = STATUS_FULL;
                     end else begin
                        // sub-stacks above the pointer are always empty
                        cur_in      = cur_ff + CUR_W'(1);
                        cnt_we      = 1'b1;
                        cnt_waddr   = cur_ff + CUR_W'(1);
                        cnt_wdata   = CNT_W'(1);
                        plate_we    = 1'b1;
                        plate_waddr = slot_of(cur_ff + CUR_W'(1), '0);
                     end
                  end else begin
                     cnt_we    = 1'b1;
                     cnt_wdata = cnt_now + CNT_W'(1);
                     plate_we  = 1'b1;
                  end
               end
               KIND_POP_AT: begin
                  fin = 1'b1;
                  if (idx_bad_ff) begin
                     fin_status = STATUS_BADIDX;
                  end else if (cnt_now == '0) begin
                     fin_status = STATUS_EMPTY;
                  end else begin
                     cnt_we    = 1'b1;
                     cnt_waddr = idx_ff;
                     cnt_wdata = cnt_now - CNT_W'(1);
                  end
               end
               default: begin
                  // pop and top
                  if (cnt_now == '0) begin
                     if (cur_ff == '0) begin
                        fin        = 1'b1;
                        fin_status = STATUS_EMPTY;
                        if (kind_ff == KIND_TOP) begin
                           fin_value = MOST_NEGATIVE;
                        end
                     end else begin
                        cur_in   = cur_ff - CUR_W'(1);
                        state_in = S_BACK;
                     end
                  end else if (kind_ff == KIND_POP) begin
                     fin       = 1'b1;
                     cnt_we    = 1'b1;
                     cnt_wdata = cnt_now - CNT_W'(1);
                  end else begin
                     state_in = S_DATA;
                  end
               end
            endcase
         end
         S_BACK: begin
            // pointer already stepped back; count of the new sub-stack
            if (cnt_now == '0) begin
               fin        = 1'b1;
               fin_status = STATUS_EMPTY;
               if (kind_ff == KIND_TOP) begin
                  fin_value = MOST_NEGATIVE;
               end
            end else if (kind_ff == KIND_POP) begin
               fin       = 1'b1;
               cnt_we    = 1'b1;
               cnt_wdata = cnt_now - CNT_W'(1);
            end else begin
               state_in = S_DATA;
            end
         end
         S_DATA: begin
            fin       = 1'b1;
            fin_value = plate_rd_ff;
         end
         S_HOLD: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         state_in = rsp_free ? S_IDLE : S_HOLD;
      end
   end

   // Count read address: in idle the request index for pop at index, else the pointer; otherwise the next pointer
   assign cnt_raddr = (state_ff == S_IDLE) ?
                      ((req_kind == KIND_POP_AT) ? CUR_W'(req_index) : cur_ff) : cur_in;

   // Mirror of sub-stack 0 count for the overall-empty flag
   assign fill0_in      = (cnt_we && cnt_waddr == '0) ? cnt_wdata : fill0_ff;
   assign fin_all_empty = (cur_in == '0) && (fill0_in == '0);

   // Response register load
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((fin || state_ff == S_HOLD) && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         fill0_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         fill0_ff     <= fill0_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_we) begin
            cnt_vld_ff[cnt_waddr] <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Payload registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= kind_type'(req_kind);
         data_ff    <= req_data;
         idx_ff     <= CUR_W'(req_index);
         idx_bad_ff <= (32'(req_index) >= NUM_STACKS);
      end
      if (fin && !rsp_free) begin
         hold_value_ff     <= fin_value;
         hold_status_ff    <= fin_status;
         hold_all_empty_ff <= fin_all_empty;
      end
      if (fin && rsp_free) begin
         rsp_value_ff     <= fin_value;
         rsp_status_ff    <= fin_status;
         rsp_all_empty_ff <= fin_all_empty;
      end else if (state_ff == S_HOLD && rsp_free) begin
         rsp_value_ff     <= hold_value_ff;
         rsp_status_ff    <= hold_status_ff;
         rsp_all_empty_ff <= hold_all_empty_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Count memory, registered read
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff     <= cnt_mem[cnt_raddr];
      cnt_vld_rd_ff <= cnt_vld_ff[cnt_raddr];
   end

   // ------------------------------------------------------------------------
   // Plate memory, registered read
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (plate_we) begin
         plate_mem[plate_waddr] <= data_ff;
      end
      plate_rd_ff <= plate_mem[plate_raddr];
   end

   // Outputs
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_all_empty = rsp_all_empty_ff;

endmodule
